/* rtl/core/fltpm_pkg.sv */
// ----------------------------------------------------------------------------
// Four-level page table mapper package
// Shared constants and types for the page table mapper.
// ----------------------------------------------------------------------------
package fltpm_pkg;

    localparam int NUM_TABLES        = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int TBL_W   = $clog2(NUM_TABLES);
    localparam int IDX_W   = $clog2(ENTRIES_PER_TABLE);
    localparam int MEM_AW  = TBL_W + IDX_W;
    localparam int CNT_W   = TBL_W + 1;

    localparam logic [1:0] REQ_MAP    = 2'd0;
    localparam logic [1:0] REQ_UNMAP  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_UNMAPPED = 2'd3;

    localparam logic CFG_ENABLE     = 1'b0;
    localparam logic CFG_TABLE_BASE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_ZERO,
        S_DONE
    } state_t;

endpackage

/* rtl/core/four_level_page_table_mapper.sv */
// ----------------------------------------------------------------------------
// Four-level page table mapper
// Walks a pool of page tables held in one synchronous memory.
// ----------------------------------------------------------------------------
// After reset the block clears the root table with busy high; configuration
// writes are taken throughout. A request is taken when start is high and busy
// is low, and its single result appears on the result ports with done high
// for one cycle. Each directory level of the walk reads its entry from memory
// and then decodes it; the leaf level has only a decode step, which writes the
// leaf entry or, for a lookup, keeps the leaf table's address. The result of
// any request, walked or rejected, appears in the cycle in which the next
// request can be taken. A walk that stops at a missing table ends at the
// decode of that level. Every table that a map allocates adds a zeroing pass,
// one entry per cycle through the single memory write port, before the walk
// carries on. The receiver cannot stall results.
module four_level_page_table_mapper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [63:0] virt_addr,
    input  logic [63:0] phys_addr,
    input  logic [11:0] page_flags,
    output logic        done,
    output logic [1:0]  status,
    output logic [51:0] leaf_table_addr,
    output logic        flush_valid,
    output logic [63:0] flush_addr,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [51:0] cfg_data
);
    import fltpm_pkg::*;

    // Table memory.
    logic [63:0] mem [0:NUM_TABLES*ENTRIES_PER_TABLE-1];
    logic [63:0] rd_data;
    logic        we;
    logic [MEM_AW-1:0] waddr, raddr;
    logic [63:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    // Registers.
    state_t state_reg, state_next;
    logic        enable_reg;
    logic [51:0] base_reg;
    logic [CNT_W-1:0] free_reg, free_next;
    logic [1:0]  lvl_reg, lvl_next;
    logic [TBL_W-1:0] tbl_reg, tbl_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [TBL_W-1:0] fresh_reg, fresh_next;
    logic [1:0]  req_reg;
    logic [63:0] va_reg, pa_reg;
    logic [11:0] fl_reg;
    logic [1:0]  st_reg, st_next;
    logic        out_reg, out_next;
    logic [51:0] leaf_reg, leaf_next;
    logic        fv_reg, fv_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            base_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ENABLE)
            begin
                enable_reg <= cfg_data[0];
            end
            else
            begin
                base_reg <= {cfg_data[51:12], 12'h000};
            end
        end
    end

    // Request checks.
    logic canon, aligned, pa_ok, accept;
    assign canon   = (virt_addr[63:48] == 16'h0000) || (virt_addr[63:48] == 16'hFFFF);
    assign aligned = (virt_addr[11:0] == 12'h000);
    assign pa_ok   = (phys_addr[11:0] == 12'h000) && (phys_addr[63:52] == 12'h000);
    assign accept  = start && (state_reg == S_IDLE);

    logic walk_ok;
    always_comb
    begin
        walk_ok = 1'b0;
        if (enable_reg && canon)
        begin
            case (req_type)
                REQ_MAP:    walk_ok = aligned && pa_ok;
                REQ_UNMAP:  walk_ok = aligned;
                REQ_LOOKUP: walk_ok = 1'b1;
                default:    walk_ok = 1'b0;
            endcase
        end
    end

    // Index for the current level.
    logic [IDX_W-1:0] lvl_ix, pt_ix;
    always_comb
    begin
        case (lvl_reg)
            2'd0:    lvl_ix = va_reg[47:39];
            2'd1:    lvl_ix = va_reg[38:30];
            default: lvl_ix = va_reg[29:21];
        endcase
    end
    assign pt_ix = va_reg[20:12];

    // Entry decode.
    logic [51:0] diff;
    logic        link_ok;
    logic [TBL_W-1:0] link_tbl;
    assign diff     = {rd_data[51:12], 12'h000} - base_reg;
    assign link_ok  = rd_data[0] && (diff[51:12] < 40'(NUM_TABLES));
    assign link_tbl = diff[12 +: TBL_W];

    // The table handed out next, and the current table, as physical addresses.
    logic [51:0] fresh_addr, tbl_addr;
    assign fresh_addr = base_reg + {{(40-TBL_W){1'b0}}, free_reg[TBL_W-1:0], 12'h000};
    assign tbl_addr   = base_reg + {{(40-TBL_W){1'b0}}, tbl_reg, 12'h000};

    // A missing directory entry on a map path takes a new table while one is free.
    logic alloc_go;
    assign alloc_go = (state_reg == S_DECIDE) && (lvl_reg != 2'd3) && !link_ok &&
                      (req_reg == REQ_MAP) && (free_reg < CNT_W'(NUM_TABLES));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        free_next  = free_reg;
        lvl_next   = lvl_reg;
        tbl_next   = tbl_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        st_next    = st_reg;
        out_next   = 1'b0;
        leaf_next  = leaf_reg;
        fv_next    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(ENTRIES_PER_TABLE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    lvl_next  = 2'd0;
                    tbl_next  = '0;
                    leaf_next = '0;
                    if (walk_ok)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        st_next    = ST_REJECT;
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (lvl_reg == 2'd3)
                begin
                    // Leaf write cycle; a lookup writes nothing and keeps the leaf table address.
                    st_next    = ST_DONE;
                    state_next = S_DONE;
                    if (req_reg == REQ_LOOKUP)
                    begin
                        leaf_next = tbl_addr;
                    end
                end
                else if (link_ok)
                begin
                    tbl_next = link_tbl;
                    lvl_next = lvl_reg + 2'd1;
                    state_next = (lvl_reg == 2'd2) ? S_DECIDE : S_READ;
                end
                else if (req_reg != REQ_MAP)
                begin
                    st_next    = ST_UNMAPPED;
                    state_next = S_DONE;
                end
                else if (free_reg >= CNT_W'(NUM_TABLES))
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    fresh_next = free_reg[TBL_W-1:0];
                    free_next  = free_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                cnt_next = cnt_reg + 1'b1;
                // Once the new table is clear, the walk carries on inside it.
                if (cnt_reg == IDX_W'(ENTRIES_PER_TABLE - 1))
                begin
                    tbl_next   = fresh_reg;
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = (lvl_reg == 2'd2) ? S_DECIDE : S_READ;
                end
            end
            S_DONE:
            begin
                out_next   = 1'b1;
                fv_next    = (st_reg == ST_DONE) && (req_reg != REQ_LOOKUP);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port control; the parent link is written when its table is taken.
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = {tbl_reg, lvl_ix};
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = {{TBL_W{1'b0}}, cnt_reg};
            end
            S_ZERO:
            begin
                we    = 1'b1;
                waddr = {fresh_reg, cnt_reg};
            end
            S_DECIDE:
            begin
                if (lvl_reg == 2'd3 && req_reg != REQ_LOOKUP)
                begin
                    we    = 1'b1;
                    waddr = {tbl_reg, pt_ix};
                    wdata = (req_reg == REQ_MAP) ?
                            {12'h000, pa_reg[51:12], fl_reg | 12'h001} : 64'd0;
                end
                else if (alloc_go)
                begin
                    we    = 1'b1;
                    waddr = {tbl_reg, lvl_ix};
                    wdata = {12'h000, fresh_addr[51:12], 12'h003};
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            free_reg  <= CNT_W'(1);
            lvl_reg   <= '0;
            tbl_reg   <= '0;
            cnt_reg   <= '0;
            fresh_reg <= '0;
            st_reg    <= ST_DONE;
            out_reg   <= 1'b0;
            fv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            lvl_reg   <= lvl_next;
            tbl_reg   <= tbl_next;
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
            st_reg    <= st_next;
            out_reg   <= out_next;
            fv_reg    <= fv_next;
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        leaf_reg <= leaf_next;
        if (accept)
        begin
            req_reg <= req_type;
            va_reg  <= virt_addr;
            pa_reg  <= phys_addr;
            fl_reg  <= page_flags;
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = out_reg;
    assign status          = st_reg;
    assign leaf_table_addr = leaf_reg;
    assign flush_valid     = fv_reg;
    assign flush_addr      = fv_reg ? va_reg : 64'd0;

endmodule
